// File: hw/rtl/crchp_pkg.sv
`default_nettype none

package crchp_pkg;

    // Header layout: byte positions within one 16-byte header
    localparam logic [3:0] PosMagic0   = 4'd0;
    localparam logic [3:0] PosMagic1   = 4'd1;
    localparam logic [3:0] PosLen0     = 4'd2;
    localparam logic [3:0] PosLen1     = 4'd3;
    localparam logic [3:0] PosLen2     = 4'd4;
    localparam logic [3:0] PosLen3     = 4'd5;
    localparam logic [3:0] PosHeight0  = 4'd6;
    localparam logic [3:0] PosHeight1  = 4'd7;
    localparam logic [3:0] PosWidth0   = 4'd8;
    localparam logic [3:0] PosWidth1   = 4'd9;
    localparam logic [3:0] PosChan0    = 4'd10;
    localparam logic [3:0] PosChan1    = 4'd11;
    localparam logic [3:0] PosOpcode0  = 4'd12;
    localparam logic [3:0] PosOpcode1  = 4'd13;
    localparam logic [3:0] PosCrcLow   = 4'd14;
    localparam logic [3:0] PosCrcHigh  = 4'd15;

    // Bytes 0 .. CrcSpan-1 go through the CRC
    localparam logic [3:0] CrcSpan     = 4'd14;

    localparam logic [15:0] CrcPoly    = 16'h1021;
    localparam logic [7:0]  MagicA     = 8'h61;  // 'a'
    localparam logic [7:0]  MagicB     = 8'h62;  // 'b'
    localparam logic [15:0] MaxChannels = 16'd4;

    // One parsed header
    typedef struct packed {
        logic        header_ok;
        logic [31:0] payload_length;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [15:0] channel_count;
        logic [15:0] operation_code;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_header_result;

    // CRC-16, poly 0x1021, MSB first, one byte unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crchp_if.sv
`default_nettype none

// Byte stream in
interface crchp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Parsed header out
interface crchp_out_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [31:0] payload_length;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [15:0] channel_count;
    logic [15:0] operation_code;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;

    modport source (output valid, input ready, output header_ok, output payload_length,
                    output image_height, output image_width, output channel_count,
                    output operation_code, output received_crc, output computed_crc);
    modport sink   (input valid, output ready, input header_ok, input payload_length,
                    input image_height, input image_width, input channel_count,
                    input operation_code, input received_crc, input computed_crc);
endinterface

`default_nettype wire

// File: hw/rtl/crchp_in_stage.sv
`default_nettype none

module crchp_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    crchp_in_if.sink   i_in,
    input  wire logic  i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // Room when empty or the held word moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Byte register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: hw/rtl/crchp_assembler.sv
`default_nettype none

module crchp_assembler
    import crchp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire logic [7:0] i_byte,
    output logic          o_last,
    output t_header_result o_result
);

    logic [3:0]  r_pos,      n_pos;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_magic0,   n_magic0;
    logic [7:0]  r_magic1,   n_magic1;
    logic [31:0] r_length,   n_length;
    logic [15:0] r_height,   n_height;
    logic [15:0] r_width,    n_width;
    logic [15:0] r_channels, n_channels;
    logic [15:0] r_opcode,   n_opcode;
    logic [7:0]  r_crc_low,  n_crc_low;
    logic [15:0] w_rx_crc;

    assign o_last = (r_pos == PosCrcHigh);

    // Field capture, CRC update and position count
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_magic0   = r_magic0;
        n_magic1   = r_magic1;
        n_length   = r_length;
        n_height   = r_height;
        n_width    = r_width;
        n_channels = r_channels;
        n_opcode   = r_opcode;
        n_crc_low  = r_crc_low;
        if (i_advance) begin
            if (r_pos < CrcSpan) begin
                n_crc = crc_byte(r_crc, i_byte);
            end
            case (r_pos)
                PosMagic0:  n_magic0            = i_byte;
                PosMagic1:  n_magic1            = i_byte;
                PosLen0:    n_length[7:0]       = i_byte;
                PosLen1:    n_length[15:8]      = i_byte;
                PosLen2:    n_length[23:16]     = i_byte;
                PosLen3:    n_length[31:24]     = i_byte;
                PosHeight0: n_height[7:0]       = i_byte;
                PosHeight1: n_height[15:8]      = i_byte;
                PosWidth0:  n_width[7:0]        = i_byte;
                PosWidth1:  n_width[15:8]       = i_byte;
                PosChan0:   n_channels[7:0]     = i_byte;
                PosChan1:   n_channels[15:8]    = i_byte;
                PosOpcode0: n_opcode[7:0]       = i_byte;
                PosOpcode1: n_opcode[15:8]      = i_byte;
                PosCrcLow:  n_crc_low           = i_byte;
                default:    ;
            endcase
            // Last byte closes the header; next word starts a new one
            if (o_last) begin
                n_pos = PosMagic0;
                n_crc = 16'h0000;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= PosMagic0;
            r_crc <= 16'h0000;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Field holds, all rewritten before each result
    always_ff @(posedge i_clk) begin
        r_magic0   <= n_magic0;
        r_magic1   <= n_magic1;
        r_length   <= n_length;
        r_height   <= n_height;
        r_width    <= n_width;
        r_channels <= n_channels;
        r_opcode   <= n_opcode;
        r_crc_low  <= n_crc_low;
    end

    // Result as seen with the final byte in hand
    assign w_rx_crc = {i_byte, r_crc_low};

    always_comb begin
        o_result.header_ok      = (r_length != 32'd0) && (r_magic0 == MagicA)
                                  && (r_magic1 == MagicB) && (r_height != 16'd0)
                                  && (r_width != 16'd0) && (r_channels != 16'd0)
                                  && (r_channels <= MaxChannels) && (w_rx_crc == r_crc);
        o_result.payload_length = r_length;
        o_result.image_height   = r_height;
        o_result.image_width    = r_width;
        o_result.channel_count  = r_channels;
        o_result.operation_code = r_opcode;
        o_result.received_crc   = w_rx_crc;
        o_result.computed_crc   = r_crc;
    end

endmodule

`default_nettype wire

// File: hw/rtl/crchp_out_reg.sv
`default_nettype none

module crchp_out_reg
    import crchp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_header_result i_result,
    output logic               o_space,
    crchp_out_if.source        o_out
);

    logic           r_valid;
    t_header_result r_result;

    // Free when empty or the held word leaves this cycle
    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.header_ok      = r_result.header_ok;
    assign o_out.payload_length = r_result.payload_length;
    assign o_out.image_height   = r_result.image_height;
    assign o_out.image_width    = r_result.image_width;
    assign o_out.channel_count  = r_result.channel_count;
    assign o_out.operation_code = r_result.operation_code;
    assign o_out.received_crc   = r_result.received_crc;
    assign o_out.computed_crc   = r_result.computed_crc;

endmodule

`default_nettype wire

// File: hw/rtl/crc_checked_header_parser_top.sv
// Header parser with CRC-16 check. Bytes arrive on i_in, one per word, and
// every 16 bytes form a header: magic 'a','b', a little-endian 32-bit payload
// length, little-endian 16-bit height, width, channels and opcode, then a
// little-endian CRC over the first 14 bytes (poly 0x1021, init 0, MSB first,
// no final XOR). After the 16th byte one word leaves on o_out with all fields,
// both CRCs and header_ok; a failed header is still reported and the next byte
// is byte 0 of a new header. Throughput is one byte per cycle while o_out is
// not stalled: each byte is held in the input register while a byte-wide
// unrolled CRC step and the field capture run, and a result is registered in
// the output register once its last byte leaves the input register. A stalled
// o_out only holds back the 16th byte of the following header.
`default_nettype none

module crc_checked_header_parser_top
    import crchp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    crchp_in_if.sink     i_in,
    crchp_out_if.source  o_out
);

    logic           w_in_valid;
    logic [7:0]     w_in_byte;
    logic           w_last;
    logic           w_space;
    logic           w_advance;
    t_header_result w_result;

    // Held byte moves on unless it completes a header and the output is full
    assign w_advance = w_in_valid && (!w_last || w_space);

    crchp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    crchp_assembler u_assembler (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (w_in_byte),
        .o_last    (w_last),
        .o_result  (w_result)
    );

    crchp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_last),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    import crchp_pkg::*;

    localparam int RandomBytes = 1626;
    localparam int IdleLimit   = 5000;
    localparam int TailCycles  = 20;

    // One byte waiting to go out; hold_off makes the sender wait for every
    // outstanding header result before this byte is offered
    typedef struct {
        logic [7:0] data;
        bit         hold_off;
    } byte_item_t;

    typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxComb} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    crchp_in_if  in_bus();
    crchp_out_if out_bus();

    crc_checked_header_parser_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    byte_item_t     byte_q[$];
    t_header_result expected_headers[$];

    int total_bytes;
    int bytes_taken;
    int hdr_pushed;
    int hdr_checked;
    int error_count;
    int good_seen;
    int bad_seen;

    // Parser shadow state
    logic [3:0]  sh_pos;
    logic [15:0] sh_crc;
    logic [7:0]  sh_magic0;
    logic [7:0]  sh_magic1;
    logic [31:0] sh_length;
    logic [15:0] sh_height;
    logic [15:0] sh_width;
    logic [15:0] sh_chan;
    logic [15:0] sh_opcode;
    logic [7:0]  sh_crc_low;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-16/XMODEM, one bit at a time, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
        end
        return c;
    endfunction

    // Build a 16-byte header; crc_flip corrupts the carried CRC, crc_swap
    // sends it big-endian instead
    task automatic queue_header(input logic [7:0] m0, input logic [7:0] m1,
                                input logic [31:0] len, input logic [15:0] ht,
                                input logic [15:0] wd, input logic [15:0] ch,
                                input logic [15:0] op, input logic [15:0] crc_flip,
                                input bit crc_swap, input bit hold);
        logic [7:0]  hb [16];
        logic [15:0] c;
        byte_item_t  it;
        hb = '{m0, m1, len[7:0], len[15:8], len[23:16], len[31:24],
               ht[7:0], ht[15:8], wd[7:0], wd[15:8], ch[7:0], ch[15:8],
               op[7:0], op[15:8], 8'h00, 8'h00};
        c = 16'h0000;
        for (int i = 0; i < int'(CrcSpan); i++) c = crc16_step(c, hb[i]);
        c = c ^ crc_flip;
        if (crc_swap) c = {c[7:0], c[15:8]};
        hb[14] = c[7:0];
        hb[15] = c[15:8];
        for (int i = 0; i < 16; i++) begin
            it.data     = hb[i];
            it.hold_off = hold && (i == 0);
            byte_q.push_back(it);
            total_bytes++;
        end
    endtask

    // Sixteen arbitrary bytes
    task automatic queue_noise(input bit hold);
        byte_item_t it;
        for (int i = 0; i < 16; i++) begin
            it.data     = 8'($urandom_range(0, 255));
            it.hold_off = hold && (i == 0);
            byte_q.push_back(it);
            total_bytes++;
        end
    endtask

    // Advance the shadow parser by one byte; a finished header is queued
    task automatic absorb_byte(input logic [7:0] b);
        t_header_result r;
        logic [15:0]    rx;
        if (sh_pos < CrcSpan) sh_crc = crc16_step(sh_crc, b);
        case (sh_pos)
            PosMagic0:  sh_magic0 = b;
            PosMagic1:  sh_magic1 = b;
            PosLen0:    sh_length[7:0]   = b;
            PosLen1:    sh_length[15:8]  = b;
            PosLen2:    sh_length[23:16] = b;
            PosLen3:    sh_length[31:24] = b;
            PosHeight0: sh_height[7:0]   = b;
            PosHeight1: sh_height[15:8]  = b;
            PosWidth0:  sh_width[7:0]    = b;
            PosWidth1:  sh_width[15:8]   = b;
            PosChan0:   sh_chan[7:0]     = b;
            PosChan1:   sh_chan[15:8]    = b;
            PosOpcode0: sh_opcode[7:0]   = b;
            PosOpcode1: sh_opcode[15:8]  = b;
            PosCrcLow:  sh_crc_low       = b;
            default: begin
                rx = {b, sh_crc_low};
                r.header_ok = (sh_magic0 == MagicA) && (sh_magic1 == MagicB) &&
                              (sh_length != 0) && (sh_height != 0) && (sh_width != 0) &&
                              (sh_chan != 0) && (sh_chan <= MaxChannels) && (rx == sh_crc);
                r.payload_length = sh_length;
                r.image_height   = sh_height;
                r.image_width    = sh_width;
                r.channel_count  = sh_chan;
                r.operation_code = sh_opcode;
                r.received_crc   = rx;
                r.computed_crc   = sh_crc;
                expected_headers.push_back(r);
                hdr_pushed <= hdr_pushed + 1;
            end
        endcase
        if (sh_pos == PosCrcHigh) begin
            sh_pos = 4'd0;
            sh_crc = 16'h0000;
        end else begin
            sh_pos = sh_pos + 4'd1;
        end
    endtask

    function automatic bit check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Byte sender: bursts and gaps, holds a word until it is taken
    int  burst_left;
    int  gap_left;
    bit  hold_seen;

    always @(posedge clk) begin : drive_bytes
        byte_item_t it;
        if (!rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.data_byte <= 8'h00;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                in_bus.valid <= 1'b0;
            end else if (byte_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (byte_q[0].hold_off && (!hold_seen || hdr_pushed != hdr_checked)) begin
                // let the output side drain completely first
                hold_seen    <= 1'b1;
                in_bus.valid <= 1'b0;
            end else begin
                it = byte_q.pop_front();
                hold_seen        <= 1'b0;
                in_bus.valid     <= 1'b1;
                in_bus.data_byte <= it.data;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Result receiver: switches between randomly chosen stall patterns
    rx_mode_e    rx_mode;
    int          mode_left;
    logic [2:0]  comb_phase;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            rx_mode       <= RxOpen;
            mode_left     <= 0;
            comb_phase    <= 3'd0;
        end else begin
            comb_phase <= comb_phase + 3'd1;
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_e'($urandom_range(0, 3));
                mode_left <= $urandom_range(64, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RxOpen:   out_bus.ready <= 1'b1;
                RxCoin:   out_bus.ready <= 1'($urandom_range(0, 1));
                RxSparse: out_bus.ready <= ($urandom_range(0, 7) == 0);
                default:  out_bus.ready <= (comb_phase < 3'd5);
            endcase
        end
    end

    // Monitor: shadow parser on accepted bytes, compare on accepted results
    always @(posedge clk) begin : watch_ports
        t_header_result got;
        t_header_result want;
        bit             ok;
        if (rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                absorb_byte(in_bus.data_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (out_bus.valid && out_bus.ready) begin
                got = {out_bus.header_ok, out_bus.payload_length, out_bus.image_height,
                       out_bus.image_width, out_bus.channel_count, out_bus.operation_code,
                       out_bus.received_crc, out_bus.computed_crc};
                if (expected_headers.size() == 0) begin
                    $display("%0t: header result with none expected, got %0h", $time, got);
                    error_count++;
                end else begin
                    want = expected_headers.pop_front();
                    hdr_checked <= hdr_checked + 1;
                    ok = 1'b1;
                    ok &= check_field("header_ok", 32'(want.header_ok), 32'(got.header_ok));
                    ok &= check_field("payload_length", want.payload_length,
                                      got.payload_length);
                    ok &= check_field("image_height", 32'(want.image_height),
                                      32'(got.image_height));
                    ok &= check_field("image_width", 32'(want.image_width),
                                      32'(got.image_width));
                    ok &= check_field("channel_count", 32'(want.channel_count),
                                      32'(got.channel_count));
                    ok &= check_field("operation_code", 32'(want.operation_code),
                                      32'(got.operation_code));
                    ok &= check_field("received_crc", 32'(want.received_crc),
                                      32'(got.received_crc));
                    ok &= check_field("computed_crc", 32'(want.computed_crc),
                                      32'(got.computed_crc));
                    if (!ok) error_count++;
                    if (want.header_ok) good_seen++;
                    else bad_seen++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving
    int idle_cycles;

    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int          pick;
        int          flaw;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [31:0] len;
        logic [15:0] ht;
        logic [15:0] wd;
        logic [15:0] ch;
        logic [15:0] op;
        logic [15:0] flip;
        int          directed_bytes;

        in_bus.valid     = 1'b0;
        in_bus.data_byte = 8'h00;
        out_bus.ready    = 1'b0;
        sh_pos = 4'd0;  sh_crc = 16'h0;  sh_magic0 = 8'h0;  sh_magic1 = 8'h0;
        sh_length = 32'h0;  sh_height = 16'h0;  sh_width = 16'h0;
        sh_chan = 16'h0;  sh_opcode = 16'h0;  sh_crc_low = 8'h0;

        // Directed corners: minimal and maximal good headers, each check failing
        queue_header(MagicA, MagicB, 32'd1, 16'd1, 16'd1, 16'd1, 16'h0000, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, MaxChannels,
                     16'hFFFF, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd64, 16'd8, 16'd8, 16'd0, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd64, 16'd8, 16'd8, 16'd5, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd64, 16'd8, 16'd8, 16'h0104, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd0, 16'd8, 16'd8, 16'd3, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd64, 16'd0, 16'd8, 16'd3, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'd64, 16'd8, 16'd0, 16'd3, 16'd3, 16'h0, 0, 0);
        queue_header(MagicB, MagicB, 32'd64, 16'd8, 16'd8, 16'd3, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicA, 32'd64, 16'd8, 16'd8, 16'd3, 16'd3, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'h0102_0304, 16'h0506, 16'h0708, 16'd2, 16'h0A0B,
                     16'h0001, 0, 0);
        queue_header(MagicA, MagicB, 32'h0102_0304, 16'h0506, 16'h0708, 16'd2, 16'h0A0B,
                     16'h0, 1, 0);
        queue_header(8'h00, 8'h00, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0, 0, 0);
        queue_header(MagicA, MagicB, 32'h8000_0000, 16'h8000, 16'h8000, 16'd4, 16'h8000,
                     16'h0, 0, 1);
        directed_bytes = total_bytes;

        // Random headers: mostly good ones, some with one flaw, some with random magic or channels, some noise
        while (total_bytes < directed_bytes + RandomBytes) begin
            m0   = MagicA;
            m1   = MagicB;
            len  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 255)) : $urandom;
            if (len == 0) len = 32'd1;
            ht   = 16'($urandom_range(1, 65535));
            wd   = 16'($urandom_range(1, 65535));
            ch   = 16'($urandom_range(1, 4));
            op   = 16'($urandom_range(0, 65535));
            flip = 16'h0;
            pick = $urandom_range(0, 99);
            if (pick >= 65 && pick < 80) begin
                flaw = $urandom_range(0, 6);
                case (flaw)
                    0: m0 = 8'($urandom_range(0, 255)) ^ ((pick[0]) ? 8'h00 : 8'h80);
                    1: m1 = 8'($urandom_range(0, 255)) ^ ((pick[0]) ? 8'h00 : 8'h80);
                    2: len = 32'd0;
                    3: ht = 16'd0;
                    4: wd = 16'd0;
                    5: ch = (pick[0]) ? 16'd0 : 16'($urandom_range(5, 65535));
                    default: flip = 16'($urandom_range(1, 65535));
                endcase
            end else if (pick >= 90) begin
                if (pick[0]) begin
                    m0 = 8'($urandom_range(0, 255));
                    m1 = 8'($urandom_range(0, 255));
                end
                ch = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                 : 16'($urandom_range(0, 65535));
            end
            if (pick >= 80 && pick < 90)
                queue_noise($urandom_range(0, 24) == 0);
            else
                queue_header(m0, m1, len, ht, wd, ch, op, flip, 0, $urandom_range(0, 24) == 0);
        end
        // make sure the drained case is exercised at least once
        byte_q[directed_bytes].hold_off = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_bytes || hdr_pushed != hdr_checked) @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (expected_headers.size() != 0) begin
            $display("%0t: %0d header results never arrived", $time, expected_headers.size());
            error_count++;
        end
        $display("Sent %0d header bytes; checked %0d headers (%0d good, %0d rejected).",
                 total_bytes, hdr_checked, good_seen, bad_seen);
        $display("Covered field extremes, every rejection reason, noise and %s",
                 "output back-pressure.");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
